>>> hdl/dsn_pkg.sv
`default_nettype none
package dsn_pkg;

   localparam int DSN_MAX_LOG_SIZE = 8;
   localparam int DSN_RANDOM_BITS  = 15;
   localparam int CFG_BITS         = 4;
   localparam int CSR_IDX_BITS     = 2;
   localparam int PIX_BITS         = 16;
   localparam int STATUS_BITS      = 3;
   localparam int CMD_BITS         = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LOG2_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOG2_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOG2_GRID   = 2'd2;

   localparam logic [CFG_BITS-1:0] CFG_LOG2_WIDTH_RST  = 4'd8;
   localparam logic [CFG_BITS-1:0] CFG_LOG2_HEIGHT_RST = 4'd8;
   localparam logic [CFG_BITS-1:0] CFG_LOG2_GRID_RST   = 4'd4;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_START = 2'd0,
      CMD_WORD  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_MORE     = 3'd0,
      ST_READY    = 3'd1,
      ST_PIXEL    = 3'd2,
      ST_GRID_BAD = 3'd3,
      ST_ORDER    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SEED,
      PH_REFINE,
      PH_READY
   } phase_type;

   typedef enum logic [1:0] {
      PS_CENTER,
      PS_EDGE_H,
      PS_EDGE_V
   } pass_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WD_WR,
      S_RF_RD,
      S_RF_ACC,
      S_RF_WR,
      S_EX_RD,
      S_EX_END,
      S_PX_DAT,
      S_PX_DIV,
      S_RESP
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

>>> hdl/dsn_if.sv
`default_nettype none
interface dsn_req_if
   import dsn_pkg::*;
#(
   parameter int RANDOM_BITS = DSN_RANDOM_BITS
);
   logic                   valid;
   logic                   ready;
   logic [CMD_BITS-1:0]    command;
   logic [RANDOM_BITS-1:0] random_word;

   modport source (output valid, output command, output random_word, input ready);
   modport sink   (input valid, input command, input random_word, output ready);
endinterface

interface dsn_rsp_if
   import dsn_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [PIX_BITS-1:0]    pixel_value;
   logic                   last_pixel;

   modport source (output valid, output status, output pixel_value, output last_pixel,
                   input ready);
   modport sink   (input valid, input status, input pixel_value, input last_pixel,
                   output ready);
endinterface
`default_nettype wire

>>> hdl/dsn_height_mem.sv
`default_nettype none
module dsn_height_mem
   import dsn_pkg::*;
#(
   parameter int AW = 2 * DSN_MAX_LOG_SIZE,
   parameter int HW = DSN_RANDOM_BITS + 2
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [HW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [HW-1:0] rd_data
);

   logic [HW-1:0] mem [(1 << AW)];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> hdl/dsn_divider.sv
`default_nettype none
module dsn_divider
   import dsn_pkg::*;
#(
   parameter int HW = DSN_RANDOM_BITS + 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [HW+PIX_BITS-1:0] numer,
   input  wire logic [HW-1:0]          denom,
   output div_stat_type                stat,
   output logic [PIX_BITS-1:0]         quot
);

   localparam int CNTW = $clog2(PIX_BITS + 1);

   // The quotient is known to fit PIX_BITS bits, so the upper numerator bits
   // seed the remainder directly.
   logic [HW-1:0]       rem_ff, rem_in;
   logic [HW-1:0]       den_ff, den_in;
   logic [PIX_BITS-1:0] low_ff, low_in;
   logic [PIX_BITS-1:0] quot_ff, quot_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [HW:0]         trial;
   logic                fits;

   assign trial = {rem_ff, low_ff[PIX_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numer[HW+PIX_BITS-1:PIX_BITS];
         low_in  = numer[PIX_BITS-1:0];
         den_in  = denom;
         quot_in = '0;
         cnt_in  = CNTW'(PIX_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? HW'(trial - {1'b0, den_ff}) : trial[HW-1:0];
         quot_in = {quot_ff[PIX_BITS-2:0], fits};
         low_in  = {low_ff[PIX_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;

endmodule
`default_nettype wire

>>> hdl/diamond_square_noise_generator_top.sv
`default_nettype none
// Diamond-square fractal height map generator with a toroidal (wrapping) map.
// Items enter on req_if (command, random_word) and every item returns exactly
// one item on rsp_if (status, pixel_value, last_pixel). The block works on one
// item at a time: req_if.ready is high only while the sequencer is idle.
// A random word updates its point in the height memory; the last word of a
// level also runs the refinement sweep of the next level: for each centre and
// each edge point four memory reads, a step to take in the last read data and
// one write, through the single-read height memory. The final word instead
// sweeps the whole map for its minimum and maximum, one pixel a cycle. A pixel
// read normalizes the height to 0..65535 with the 16-step restoring divider;
// on a flat map no division runs.
// Results sit in an output register; a new item is accepted while an earlier
// result still waits there, and the sequencer only stalls when it must hand
// over a new result while the receiver is still holding back the previous one.
// Synchronous reset returns the block to idle with the configuration registers
// at their default values; the height memory is not cleared, since a run only
// reads points that it wrote. Configuration writes take effect at the next start.
module diamond_square_noise_generator_top
   import dsn_pkg::*;
#(
   parameter int MAX_LOG_SIZE = DSN_MAX_LOG_SIZE,
   parameter int RANDOM_BITS  = DSN_RANDOM_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   dsn_req_if.sink                      req_if,
   dsn_rsp_if.source                    rsp_if,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]     csr_data
);

   localparam int ML = MAX_LOG_SIZE;
   localparam int RB = RANDOM_BITS;
   localparam int CW = ML + 1;          // coordinates and spacing, can hold the size
   localparam int AW = 2 * ML;          // height memory address
   localparam int HW = RB + 2;          // stored height
   localparam int LW = $clog2(ML + 1);  // latched log2 sizes
   localparam int NW = HW + PIX_BITS;   // scaled numerator

   // Configuration registers.
   logic [CFG_BITS-1:0] cfg_lw_ff, cfg_lh_ff, cfg_lg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_lw_ff <= CFG_LOG2_WIDTH_RST;
         cfg_lh_ff <= CFG_LOG2_HEIGHT_RST;
         cfg_lg_ff <= CFG_LOG2_GRID_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOG2_WIDTH:  cfg_lw_ff <= csr_data;
            CSR_LOG2_HEIGHT: cfg_lh_ff <= csr_data;
            CSR_LOG2_GRID:   cfg_lg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   function automatic logic [LW-1:0] sat_log(input logic [CFG_BITS-1:0] v);
      logic [LW-1:0] r;
      r = (v > CFG_BITS'(ML)) ? LW'(ML) : LW'(v);
      return r;
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [ML-1:0] x, input logic [ML-1:0] y,
                                                input logic [ML-1:0] wm, input logic [ML-1:0] hm,
                                                input logic [LW-1:0] lw);
      logic [AW-1:0] a;
      a = (AW'(y & hm) << lw) | AW'(x & wm);
      return a;
   endfunction

   // Sequencer state and run registers.
   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   pass_type            pass_ff, pass_in;
   logic [LW-1:0]       run_lw_ff, run_lw_in, run_lh_ff, run_lh_in;
   logic [CW-1:0]       grid_ff, grid_in;
   logic [RB-1:0]       mask_ff, mask_in;
   logic [CW-1:0]       cx_ff, cx_in, cy_ff, cy_in;
   logic [CW-1:0]       px_ff, px_in, py_ff, py_in;
   logic [1:0]          k_ff, k_in;
   logic [HW+1:0]       acc_ff, acc_in;
   logic                rvalid_ff, rvalid_in;
   logic [AW:0]         ex_cnt_ff, ex_cnt_in;
   logic                ex_first_ff, ex_first_in;
   logic [HW-1:0]       min_ff, min_in, max_ff, max_in;
   logic [RB-1:0]       word_ff, word_in;
   status_type          res_status_ff, res_status_in;
   logic [PIX_BITS-1:0] res_pix_ff, res_pix_in;
   logic                res_last_ff, res_last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [PIX_BITS-1:0] rsp_pix_ff, rsp_pix_in;
   logic                rsp_last_ff, rsp_last_in;

   // Memory and divider connections.
   logic                mem_we;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [HW-1:0]       mem_wdata, rd_data;
   logic                div_start;
   logic [NW-1:0]       div_num;
   div_stat_type        div_stat;
   logic [PIX_BITS-1:0] div_quot;

   dsn_height_mem #(.AW(AW), .HW(HW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   dsn_divider #(.HW(HW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (max_ff - min_ff),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // Shared arithmetic.
   command_type   cmd;
   logic          accept;
   logic          rsp_free;
   logic [CW-1:0] w, h, g2c;
   logic [ML-1:0] wm, hm, gg, g2;
   logic [LW-1:0] st_lw, st_lh, st_lg;
   logic          start_bad;
   logic [CW-1:0] wd_ncx, wd_ncy, px_ncx, px_ncy, rf_npx, rf_npy;
   logic          wd_xwrap, wd_ywrap, px_xwrap, px_ywrap, rf_xwrap, rf_ywrap;
   logic [AW:0]   ex_n;
   logic          ex_last;
   logic [RB-1:0] masked;
   logic [HW-1:0] diff;
   logic          flat;
   logic [ML-1:0] rx, ry, tx, ty;
   logic [AW-1:0] cur_addr;

   assign cmd       = command_type'(req_if.command);
   assign accept    = req_if.valid && req_if.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;
   assign w         = CW'(1) << run_lw_ff;
   assign h         = CW'(1) << run_lh_ff;
   assign wm        = ML'(w - 1'b1);
   assign hm        = ML'(h - 1'b1);
   assign g2c       = CW'(grid_ff << 1);
   assign gg        = grid_ff[ML-1:0];
   assign g2        = g2c[ML-1:0];
   assign st_lw     = sat_log(cfg_lw_ff);
   assign st_lh     = sat_log(cfg_lh_ff);
   assign st_lg     = sat_log(cfg_lg_ff);
   assign start_bad = (st_lg > st_lw) || (st_lg > st_lh);

   assign wd_ncx    = cx_ff + grid_ff;
   assign wd_ncy    = cy_ff + grid_ff;
   assign wd_xwrap  = wd_ncx >= w;
   assign wd_ywrap  = wd_ncy >= h;
   assign px_ncx    = cx_ff + 1'b1;
   assign px_ncy    = cy_ff + 1'b1;
   assign px_xwrap  = px_ncx >= w;
   assign px_ywrap  = px_ncy >= h;
   assign rf_npx    = px_ff + g2c;
   assign rf_npy    = py_ff + g2c;
   assign rf_xwrap  = rf_npx >= w;
   assign rf_ywrap  = rf_npy >= h;
   assign ex_n      = (AW+1)'(1) << ((LW+1)'(run_lw_ff) + (LW+1)'(run_lh_ff));
   assign ex_last   = ex_cnt_ff == ex_n - 1'b1;
   assign masked    = word_ff & mask_ff;
   assign diff      = rd_data - min_ff;
   assign flat      = max_ff == min_ff;
   assign div_num   = {diff, {PIX_BITS{1'b0}}} - NW'(diff);
   assign cur_addr  = cell_addr(cx_ff[ML-1:0], cy_ff[ML-1:0], wm, hm, run_lw_ff);

   // Neighbour coordinates of the refinement sweep. Centres read the four
   // square corners; edge points read the two corners beside them and the
   // two centres across, all wrapping around the map.
   always_comb begin
      rx = px_ff[ML-1:0];
      ry = py_ff[ML-1:0];
      tx = px_ff[ML-1:0];
      ty = py_ff[ML-1:0];
      case (pass_ff)
         PS_CENTER: begin
            tx = px_ff[ML-1:0] + gg;
            ty = py_ff[ML-1:0] + gg;
            rx = px_ff[ML-1:0] + (k_ff[0] ? g2 : '0);
            ry = py_ff[ML-1:0] + (k_ff[1] ? g2 : '0);
         end
         PS_EDGE_H: begin
            tx = px_ff[ML-1:0] + gg;
            case (k_ff)
               2'd0: ;
               2'd1: rx = px_ff[ML-1:0] + g2;
               2'd2: begin
                  rx = px_ff[ML-1:0] + gg;
                  ry = py_ff[ML-1:0] - gg;
               end
               default: begin
                  rx = px_ff[ML-1:0] + gg;
                  ry = py_ff[ML-1:0] + gg;
               end
            endcase
         end
         default: begin
            ty = py_ff[ML-1:0] + gg;
            case (k_ff)
               2'd0: ;
               2'd1: ry = py_ff[ML-1:0] + g2;
               2'd2: begin
                  rx = px_ff[ML-1:0] - gg;
                  ry = py_ff[ML-1:0] + gg;
               end
               default: begin
                  rx = px_ff[ML-1:0] + gg;
                  ry = py_ff[ML-1:0] + gg;
               end
            endcase
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (cmd == CMD_WORD && (phase_ff == PH_SEED || phase_ff == PH_REFINE)) begin
                  state_in = S_WD_WR;
               end else if (cmd == CMD_READ && phase_ff == PH_READY) begin
                  state_in = S_PX_DAT;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_WD_WR: begin
            if (wd_xwrap && wd_ywrap) begin
               state_in = (grid_ff > CW'(1)) ? S_RF_RD : S_EX_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RF_RD:  state_in = (k_ff == 2'd3) ? S_RF_ACC : S_RF_RD;
         S_RF_ACC: state_in = S_RF_WR;
         S_RF_WR: begin
            state_in = S_RF_RD;
            if (rf_xwrap && rf_ywrap && pass_ff == PS_EDGE_V) begin
               state_in = S_RESP;
            end
         end
         S_EX_RD:  state_in = ex_last ? S_EX_END : S_EX_RD;
         S_EX_END: state_in = S_RESP;
         S_PX_DAT: state_in = flat ? S_RESP : S_PX_DIV;
         S_PX_DIV: state_in = div_stat.done ? S_RESP : S_PX_DIV;
         S_RESP:   state_in = rsp_free ? S_IDLE : S_RESP;
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      phase_in      = phase_ff;
      pass_in       = pass_ff;
      run_lw_in     = run_lw_ff;
      run_lh_in     = run_lh_ff;
      grid_in       = grid_ff;
      mask_in       = mask_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      k_in          = k_ff;
      ex_cnt_in     = ex_cnt_ff;
      ex_first_in   = ex_first_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      word_in       = word_ff;
      res_status_in = res_status_ff;
      res_pix_in    = res_pix_ff;
      res_last_in   = res_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_addr;
      mem_wdata     = HW'(masked);
      mem_raddr     = cur_addr;
      div_start     = 1'b0;
      rvalid_in     = 1'b0;

      // Four-neighbour sum, cleared outside the read phase of a point.
      acc_in = '0;
      if (state_ff == S_RF_RD || state_ff == S_RF_ACC) begin
         acc_in = rvalid_ff ? acc_ff + (HW+2)'(rd_data) : acc_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               word_in       = req_if.random_word;
               res_status_in = ST_ORDER;
               res_pix_in    = '0;
               res_last_in   = 1'b0;
               case (cmd)
                  CMD_START: begin
                     if (start_bad) begin
                        phase_in      = PH_IDLE;
                        res_status_in = ST_GRID_BAD;
                     end else begin
                        run_lw_in     = st_lw;
                        run_lh_in     = st_lh;
                        grid_in       = CW'(1) << st_lg;
                        mask_in       = '1;
                        cx_in         = '0;
                        cy_in         = '0;
                        phase_in      = PH_SEED;
                        res_status_in = ST_MORE;
                     end
                  end
                  CMD_WORD: begin
                     if (phase_ff == PH_SEED || phase_ff == PH_REFINE) begin
                        res_status_in = ST_MORE;
                     end
                  end
                  CMD_READ: begin
                     if (phase_ff == PH_READY) begin
                        res_status_in = ST_PIXEL;
                        cx_in         = px_xwrap ? '0 : px_ncx;
                        if (px_xwrap) begin
                           cy_in = px_ywrap ? '0 : px_ncy;
                        end
                        res_last_in = px_xwrap && px_ywrap;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_WD_WR: begin
            mem_we    = 1'b1;
            mem_wdata = (phase_ff == PH_SEED) ? HW'(masked) : rd_data + HW'(masked);
            cx_in     = wd_xwrap ? '0 : wd_ncx;
            if (wd_xwrap) begin
               cy_in = wd_ywrap ? '0 : wd_ncy;
            end
            if (wd_xwrap && wd_ywrap) begin
               if (grid_ff > CW'(1)) begin
                  grid_in = grid_ff >> 1;
                  mask_in = mask_ff >> 1;
                  px_in   = '0;
                  py_in   = '0;
                  k_in    = '0;
                  pass_in = PS_CENTER;
               end else begin
                  ex_cnt_in   = '0;
                  ex_first_in = 1'b1;
               end
            end
         end
         S_RF_RD: begin
            mem_raddr = cell_addr(rx, ry, wm, hm, run_lw_ff);
            rvalid_in = 1'b1;
            k_in      = k_ff + 1'b1;
         end
         S_RF_ACC: ;
         S_RF_WR: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(tx, ty, wm, hm, run_lw_ff);
            mem_wdata = acc_ff[HW+1:2];
            px_in     = rf_xwrap ? '0 : rf_npx;
            if (rf_xwrap) begin
               py_in = rf_ywrap ? '0 : rf_npy;
               if (rf_ywrap) begin
                  case (pass_ff)
                     PS_CENTER: pass_in = PS_EDGE_H;
                     PS_EDGE_H: pass_in = PS_EDGE_V;
                     default: begin
                        phase_in      = PH_REFINE;
                        res_status_in = ST_MORE;
                     end
                  endcase
               end
            end
         end
         S_EX_RD: begin
            mem_raddr = ex_cnt_ff[AW-1:0];
            rvalid_in = 1'b1;
            ex_cnt_in = ex_cnt_ff + 1'b1;
         end
         S_EX_END: begin
            phase_in      = PH_READY;
            res_status_in = ST_READY;
         end
         S_PX_DAT: begin
            div_start = !flat;
         end
         S_PX_DIV: begin
            if (div_stat.done) begin
               res_pix_in = div_quot;
            end
         end
         default: ;
      endcase

      // Running extremes over the readout sweep.
      if (rvalid_ff && (state_ff == S_EX_RD || state_ff == S_EX_END)) begin
         ex_first_in = 1'b0;
         if (ex_first_ff) begin
            min_in = rd_data;
            max_in = rd_data;
         end else begin
            if (rd_data < min_ff) min_in = rd_data;
            if (rd_data > max_ff) max_in = rd_data;
         end
      end
   end

   // Output register: loaded from the staged result, held while stalled.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pix_in    = rsp_pix_ff;
      rsp_last_in   = rsp_last_ff;
      if (state_ff == S_RESP && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_pix_in    = res_pix_ff;
         rsp_last_in   = res_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         run_lw_ff    <= '0;
         run_lh_ff    <= '0;
         grid_ff      <= '0;
         mask_ff      <= '0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= PS_CENTER;
         k_ff         <= '0;
         ex_first_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         run_lw_ff    <= run_lw_in;
         run_lh_ff    <= run_lh_in;
         grid_ff      <= grid_in;
         mask_ff      <= mask_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
         k_ff         <= k_in;
         ex_first_ff  <= ex_first_in;
      end
      px_ff         <= px_in;
      py_ff         <= py_in;
      acc_ff        <= acc_in;
      ex_cnt_ff     <= ex_cnt_in;
      word_ff       <= word_in;
      res_status_ff <= res_status_in;
      res_pix_ff    <= res_pix_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pix_ff    <= rsp_pix_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_if.ready       = state_ff == S_IDLE;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.pixel_value = rsp_pix_ff;
   assign rsp_if.last_pixel  = rsp_last_ff;

   // Only a pixel result carries a value or a last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.status != ST_PIXEL) |-> (rsp_if.pixel_value == '0) &&
      !rsp_if.last_pixel)
      else $error("non-pixel result carries pixel data");

   // The divider is never restarted while a division is in flight.
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // A finished map always has an ordered range.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_READY |-> min_ff <= max_ff)
      else $error("map extremes out of order");

endmodule
`default_nettype wire
